// ===== rtl/muller_root_step_real_unit_defines.svh =====
`ifndef MULLER_ROOT_STEP_REAL_UNIT_DEFINES_SVH
`define MULLER_ROOT_STEP_REAL_UNIT_DEFINES_SVH

// Clocked assertion, held off while reset is low.
`define MRS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition in one cycle implies a check in the next.
`define MRS_ASSERT_NEXT(name, pre, post, msg) \
  `MRS_ASSERT(name, (pre) |=> (post), msg)

`endif

// ===== rtl/mrs_pkg.sv =====
`timescale 1ns / 1ps
package mrs_pkg;

  localparam int W    = 48;  // value width
  localparam int F    = 32;  // fraction bits
  localparam int ITW  = 16;  // iteration count width
  localparam int IDXW = 3;   // config index width

  localparam int SQ        = (W + F + 1) / 2;     // root bits
  localparam int SQ_PAD    = 2 * SQ - (W + F);
  localparam int XW        = W + F + 2;           // operand shifter
  localparam int AW        = 2 * W;               // accumulator / remainder
  localparam int QW        = (SQ > W + 1) ? SQ : W + 1;
  localparam int DIV_STEPS = W + 1 + F;
  localparam int MUL_STEPS = W;
  localparam int CW        = $clog2(XW + 1);

  typedef logic signed [W-1:0] val_t;
  typedef logic signed [W:0]   wval_t;
  typedef logic [W-1:0]        mag_t;

  localparam val_t VMAX = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_EVAL    = 3'd0,
    ST_CONV    = 3'd1,
    ST_LIMIT   = 3'd2,
    ST_COMPLEX = 3'd3,
    ST_ZERO    = 3'd4,
    ST_OVF     = 3'd5,
    ST_IDLE    = 3'd6
  } stat_e;

  typedef enum logic [1:0] {
    PH_IDLE, PH_WAIT0, PH_WAIT1, PH_WAIT2
  } phase_e;

  typedef enum logic [IDXW-1:0] {
    CFG_FIRST  = 3'd0,
    CFG_SECOND = 3'd1,
    CFG_THIRD  = 3'd2,
    CFG_TOL    = 3'd3,
    CFG_LIMIT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_DIV, OP_MUL, OP_SQRT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_D0, S_D1, S_A, S_AH, S_BB, S_AC, S_SQ, S_DX, S_OUT
  } state_e;

  typedef struct packed {
    logic  start;
    op_e   op;
    logic  inv;    // flip quotient sign (negated numerator)
    wval_t opa;
    val_t  opb;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
    val_t val;
  } unit_rsp_t;

  typedef struct packed {
    val_t val;
    logic ovf;
  } sum_t;

  function automatic sum_t addc(val_t a, val_t b, logic sub);
    logic [W:0] s;
    sum_t       r;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    r.val = s[W-1:0];
    r.ovf = s[W] ^ s[W-1];
    return r;
  endfunction

  function automatic mag_t vmag(val_t a);
    return a[W-1] ? mag_t'(-a) : mag_t'(a);
  endfunction

endpackage

// ===== rtl/mrs_unit.sv =====
`timescale 1ns / 1ps
module mrs_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrs_pkg::unit_req_t req_i,
  output mrs_pkg::unit_rsp_t rsp_o
);
  import mrs_pkg::*;

  op_e             op_q;
  logic            neg_q, busy_q, done_q, ovf_q;
  logic [CW-1:0]   cnt_q;
  logic [XW-1:0]   x_q;
  logic [AW-1:0]   acc_q;
  logic [QW-1:0]   q_q;
  logic [W-1:0]    m_q;

  logic [W:0]      amag;
  mag_t            lmag, bmag;
  logic [W+F-1:0]  sqn;
  logic [XW-1:0]   x_start;
  logic            neg_start, last;
  logic [W:0]      dt, dr;
  logic            dge;
  logic [AW-1:0]   mt;
  logic [SQ+2:0]   st, strial, sr;
  logic            sge;
  logic [W:0]      qm;
  logic [AW:0]     pw, sp;
  logic signed [AW:0] sh;
  logic [AW-W+1:0] hi;
  logic            fit;
  val_t            res;

  // operand setup
  always_comb begin
    amag = req_i.opa[W] ? (W+1)'(-req_i.opa) : (W+1)'(req_i.opa);
    lmag = vmag(req_i.opa[W-1:0]);
    bmag = vmag(req_i.opb);
    sqn  = {req_i.opa[W-1:0], {F{1'b0}}};
    case (req_i.op)
      OP_MUL: begin
        x_start   = {lmag, {(F+2){1'b0}}};
        neg_start = req_i.opa[W-1] ^ req_i.opb[W-1];
      end
      OP_SQRT: begin
        x_start   = {sqn, 2'b00} >> SQ_PAD;
        neg_start = 1'b0;
      end
      default: begin
        x_start   = {amag, {(F+1){1'b0}}};
        neg_start = req_i.opa[W] ^ req_i.opb[W-1] ^ req_i.inv;
      end
    endcase
  end

  // one step of each operation
  always_comb begin
    dt     = {acc_q[W-1:0], x_q[XW-1]};
    dge    = dt >= {1'b0, m_q};
    dr     = dge ? dt - {1'b0, m_q} : dt;
    mt     = {acc_q[AW-2:0], 1'b0} + {{(AW-W){1'b0}}, (x_q[XW-1] ? m_q : {W{1'b0}})};
    st     = {acc_q[SQ:0], x_q[XW-1:XW-2]};
    strial = {1'b0, q_q[SQ-1:0], 2'b01};
    sge    = st >= strial;
    sr     = sge ? st - strial : st;
    case (op_q)
      OP_MUL:  last = cnt_q == CW'(MUL_STEPS - 1);
      OP_SQRT: last = cnt_q == CW'(SQ - 1);
      default: last = cnt_q == CW'(DIV_STEPS - 1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      neg_q <= neg_start;
      x_q   <= x_start;
      m_q   <= (req_i.op == OP_SQRT) ? {W{1'b0}} : bmag;
      acc_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          acc_q <= mt;
          x_q   <= {x_q[XW-2:0], 1'b0};
        end
        OP_SQRT: begin
          acc_q <= {{(AW-SQ-3){1'b0}}, sr};
          q_q   <= {q_q[QW-2:0], sge};
          x_q   <= {x_q[XW-3:0], 2'b00};
        end
        default: begin
          acc_q <= {{(AW-W){1'b0}}, dr[W-1:0]};
          ovf_q <= ovf_q | q_q[W];
          q_q   <= {q_q[QW-2:0], dge};
          x_q   <= {x_q[XW-2:0], 1'b0};
        end
      endcase
    end
  end

  // final scaling and range check
  always_comb begin
    qm = q_q[W:0];
    pw = {1'b0, acc_q};
    sp = neg_q ? -pw : pw;
    sh = $signed(sp) >>> F;
    hi = sh[AW:W-1];
    case (op_q)
      OP_MUL: begin
        fit = (&hi) | ~(|hi);
        res = sh[W-1:0];
      end
      OP_SQRT: begin
        fit = q_q <= {{(QW-W){1'b0}}, VMAX};
        res = q_q[W-1:0];
      end
      default: begin
        fit = !ovf_q && !qm[W] && (!qm[W-1] || (neg_q && qm[W-2:0] == '0));
        res = neg_q ? val_t'(-qm[W-1:0]) : val_t'(qm[W-1:0]);
      end
    endcase
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    rsp_o.ovf  = !fit;
    rsp_o.val  = res;
  end

endmodule

// ===== rtl/muller_root_step_real_unit.sv =====
`timescale 1ns / 1ps
// Muller root-finding engine, real Q16.32; f(x) is evaluated by the caller.
// Input channel (in_valid_i/in_ready_o): one word per step. mode_i=0 starts a
// solve; mode_i=1 brings f at the point last asked for in function_value_i.
// Output channel (out_valid_o/out_ready_i): exactly one word per input word:
// next point to evaluate (status evaluate) or the final point with a stop
// status and |f| in residual_o. iterations_o counts parabola steps.
// Config channel (cfg_valid_i/cfg_ready_o): always ready; index 0..2 starting
// points (taken at start), 3 tolerance, 4 iteration limit.
// Start, first two values, limit/converge hits and idle values pass from
// the idle state through the output state into the output register. A full
// parabola step runs the shared shift/add unit four times as a divider
// (W+F+1 = 81 steps each), three times as a multiplier (48 steps each) and
// once as a square root (40 steps); that unit sets the rate. One word in
// flight at a time.
// A stalled receiver holds the result word; the engine waits in its output
// state, in_ready_o stays low until the word has been loaded.
// Reset: engine idle, no word pending, config registers at their defaults.
module muller_root_step_real_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  mrs_pkg::val_t              function_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mrs_pkg::val_t              point_o,
  output logic [2:0]                 status_o,
  output logic [mrs_pkg::ITW-1:0]    iterations_o,
  output logic [mrs_pkg::W-2:0]      residual_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [mrs_pkg::IDXW-1:0]   cfg_index_i,
  input  mrs_pkg::val_t              cfg_data_i
);
  import mrs_pkg::*;

  state_e          state_q, state_d;
  phase_e          phase_q;
  logic [ITW-1:0]  step_q, lim_q;
  logic            issued_q;
  val_t            first_q, second_q, third_q;
  logic [W-2:0]    tol_q;

  val_t            pts_q [3];
  val_t            vals_q [3];
  val_t            h0_q, h1_q, d0_q, d1_q, a_q, b_q, tmp_q;
  val_t            pend_point_q;
  stat_e           pend_stat_q;
  logic [W-2:0]    resid_q;

  logic            out_valid_q;
  val_t            out_point_q;
  stat_e           out_stat_q;
  logic [ITW-1:0]  out_iter_q;
  logic [W-2:0]    out_resid_q;

  unit_req_t       req;
  unit_rsp_t       rsp;

  logic            in_fire, cfg_fire, slot_free, quick, stop, dx_ok;
  mag_t            fmag;
  logic [W-2:0]    fsat;
  logic            lim_hit, conv;
  sum_t            r1, r2, rh, rb, rd, re1, re2, rx;
  val_t            ac4, den;
  logic            ac4_ovf, fail;
  stat_e           fail_st;

  mrs_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_fire   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire  = cfg_valid_i;
  assign slot_free = !out_valid_q || out_ready_i;

  // incoming value checks
  always_comb begin
    fmag    = vmag(function_value_i);
    fsat    = fmag[W-1] ? {(W-1){1'b1}} : fmag[W-2:0];
    lim_hit = step_q >= lim_q;
    conv    = fmag < {1'b0, tol_q};
    quick   = !mode_i || (phase_q != PH_WAIT2) || lim_hit || conv;
  end

  // adds and range checks around the shared unit
  always_comb begin
    r1      = addc(pts_q[1], pts_q[0], 1'b1);
    r2      = addc(pts_q[2], pts_q[1], 1'b1);
    rh      = addc(h1_q, h0_q, 1'b0);
    rb      = addc(rsp.val, d1_q, 1'b0);
    ac4     = {rsp.val[W-3:0], 2'b00};
    ac4_ovf = !((&rsp.val[W-1:W-3]) || !(|rsp.val[W-1:W-3]));
    rd      = addc(tmp_q, ac4, 1'b1);
    re1     = addc(b_q, rsp.val, 1'b0);
    re2     = addc(b_q, rsp.val, 1'b1);
    den     = (vmag(re1.val) > vmag(re2.val)) ? re1.val : re2.val;
    rx      = addc(pts_q[2], rsp.val, 1'b0);
    fail    = 1'b0;
    fail_st = ST_OVF;
    case (state_q)
      S_DIFF: begin
        if (r1.ovf || r2.ovf) begin
          fail = 1'b1;
        end else if (r1.val == '0 || r2.val == '0) begin
          fail = 1'b1; fail_st = ST_ZERO;
        end
      end
      S_D0, S_A, S_BB: fail = rsp.ovf;
      S_D1: begin
        if (rsp.ovf || rh.ovf) begin
          fail = 1'b1;
        end else if (rh.val == '0) begin
          fail = 1'b1; fail_st = ST_ZERO;
        end
      end
      S_AH: fail = rsp.ovf || rb.ovf;
      S_AC: begin
        if (rsp.ovf || ac4_ovf || rd.ovf) begin
          fail = 1'b1;
        end else if (rd.val[W-1]) begin
          fail = 1'b1; fail_st = ST_COMPLEX;
        end
      end
      S_SQ: begin
        if (rsp.ovf || re1.ovf || re2.ovf) begin
          fail = 1'b1;
        end else if (den == '0) begin
          fail = 1'b1; fail_st = ST_ZERO;
        end
      end
      S_DX: fail = rsp.ovf || rx.ovf;
      default: fail = 1'b0;
    endcase
    stop  = fail && (state_q == S_DIFF || rsp.done);
    dx_ok = state_q == S_DX && rsp.done && !fail;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = quick ? S_OUT : S_DIFF;
      S_DIFF: state_d = fail ? S_OUT : S_D0;
      S_D0:   if (rsp.done) state_d = fail ? S_OUT : S_D1;
      S_D1:   if (rsp.done) state_d = fail ? S_OUT : S_A;
      S_A:    if (rsp.done) state_d = fail ? S_OUT : S_AH;
      S_AH:   if (rsp.done) state_d = fail ? S_OUT : S_BB;
      S_BB:   if (rsp.done) state_d = fail ? S_OUT : S_AC;
      S_AC:   if (rsp.done) state_d = fail ? S_OUT : S_SQ;
      S_SQ:   if (rsp.done) state_d = fail ? S_OUT : S_DX;
      S_DX:   if (rsp.done) state_d = S_OUT;
      S_OUT:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs: handshake and unit requests
  always_comb begin
    in_ready_o = state_q == S_IDLE;
    req.start  = 1'b0;
    req.op     = OP_DIV;
    req.inv    = 1'b0;
    req.opa    = {vals_q[1][W-1], vals_q[1]} - {vals_q[0][W-1], vals_q[0]};
    req.opb    = h0_q;
    case (state_q)
      S_D0: req.start = !issued_q;
      S_D1: begin
        req.start = !issued_q;
        req.opa   = {vals_q[2][W-1], vals_q[2]} - {vals_q[1][W-1], vals_q[1]};
        req.opb   = h1_q;
      end
      S_A: begin
        req.start = !issued_q;
        req.opa   = {d1_q[W-1], d1_q} - {d0_q[W-1], d0_q};
        req.opb   = tmp_q;
      end
      S_AH: begin
        req.start = !issued_q;
        req.op    = OP_MUL;
        req.opa   = {a_q[W-1], a_q};
        req.opb   = h1_q;
      end
      S_BB: begin
        req.start = !issued_q;
        req.op    = OP_MUL;
        req.opa   = {b_q[W-1], b_q};
        req.opb   = b_q;
      end
      S_AC: begin
        req.start = !issued_q;
        req.op    = OP_MUL;
        req.opa   = {a_q[W-1], a_q};
        req.opb   = vals_q[2];
      end
      S_SQ: begin
        req.start = !issued_q;
        req.op    = OP_SQRT;
        req.opa   = {tmp_q[W-1], tmp_q};
      end
      S_DX: begin
        // -2*f2 / den: pass 2*f2 and flip the sign
        req.start = !issued_q;
        req.inv   = 1'b1;
        req.opa   = {vals_q[2], 1'b0};
        req.opb   = tmp_q;
      end
      default: req.start = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      step_q      <= '0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      first_q     <= '0;
      second_q    <= val_t'(1) <<< (F - 1);
      third_q     <= -(val_t'(1) <<< (F - 1));
      tol_q       <= (W-1)'(4295);
      lim_q       <= ITW'(100);
    end else begin
      state_q <= state_d;
      if (req.start) begin
        issued_q <= 1'b1;
      end else if (rsp.done) begin
        issued_q <= 1'b0;
      end
      if (in_fire) begin
        if (!mode_i) begin
          step_q  <= '0;
          phase_q <= PH_WAIT0;
        end else begin
          case (phase_q)
            PH_WAIT0: phase_q <= PH_WAIT1;
            PH_WAIT1: phase_q <= PH_WAIT2;
            PH_WAIT2: if (lim_hit || conv) phase_q <= PH_IDLE;
            default:  phase_q <= PH_IDLE;
          endcase
        end
      end
      if (stop) phase_q <= PH_IDLE;
      if (dx_ok) step_q <= step_q + 1'b1;
      if (state_q == S_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FIRST:  first_q  <= cfg_data_i;
          CFG_SECOND: second_q <= cfg_data_i;
          CFG_THIRD:  third_q  <= cfg_data_i;
          CFG_TOL:    tol_q    <= cfg_data_i[W-2:0];
          CFG_LIMIT:  lim_q    <= cfg_data_i[ITW-1:0];
          default:    ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!mode_i) begin
        pts_q[0]     <= first_q;
        pts_q[1]     <= second_q;
        pts_q[2]     <= third_q;
        pend_point_q <= first_q;
        pend_stat_q  <= ST_EVAL;
        resid_q      <= '0;
      end else begin
        case (phase_q)
          PH_WAIT0: begin
            vals_q[0]    <= function_value_i;
            pend_point_q <= pts_q[1];
            pend_stat_q  <= ST_EVAL;
            resid_q      <= '0;
          end
          PH_WAIT1: begin
            vals_q[1]    <= function_value_i;
            pend_point_q <= pts_q[2];
            pend_stat_q  <= ST_EVAL;
            resid_q      <= '0;
          end
          PH_WAIT2: begin
            vals_q[2]    <= function_value_i;
            pend_point_q <= pts_q[2];
            pend_stat_q  <= lim_hit ? ST_LIMIT : ST_CONV;
            resid_q      <= fsat;
          end
          default: begin
            pend_point_q <= '0;
            pend_stat_q  <= ST_IDLE;
            resid_q      <= '0;
          end
        endcase
      end
    end
    if (state_q == S_DIFF) begin
      h0_q <= r1.val;
      h1_q <= r2.val;
    end
    if (rsp.done) begin
      case (state_q)
        S_D0: d0_q <= rsp.val;
        S_D1: begin
          d1_q  <= rsp.val;
          tmp_q <= rh.val;
        end
        S_A:  a_q   <= rsp.val;
        S_AH: b_q   <= rb.val;
        S_BB: tmp_q <= rsp.val;
        S_AC: tmp_q <= rd.val;
        S_SQ: tmp_q <= den;
        default: ;
      endcase
    end
    if (dx_ok) begin
      pts_q[0]     <= pts_q[1];
      vals_q[0]    <= vals_q[1];
      pts_q[1]     <= pts_q[2];
      vals_q[1]    <= vals_q[2];
      pts_q[2]     <= rx.val;
      pend_point_q <= rx.val;
      pend_stat_q  <= ST_EVAL;
      resid_q      <= '0;
    end
    if (stop) begin
      pend_point_q <= pts_q[2];
      pend_stat_q  <= fail_st;
    end
    if (state_q == S_OUT && slot_free) begin
      out_point_q <= pend_point_q;
      out_stat_q  <= pend_stat_q;
      out_iter_q  <= step_q;
      out_resid_q <= resid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign point_o      = out_point_q;
  assign status_o     = out_stat_q;
  assign iterations_o = out_iter_q;
  assign residual_o   = out_resid_q;

endmodule

// ===== rtl/mrs_chk.sv =====
`timescale 1ns / 1ps
`include "muller_root_step_real_unit_defines.svh"
module mrs_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input mrs_pkg::val_t           point_o,
  input logic [2:0]              status_o,
  input logic [mrs_pkg::W-2:0]   residual_o
);
  import mrs_pkg::*;

  // one word in flight: ready drops right after a word is taken
  `MRS_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "accepted twice")
  `MRS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(point_o), "output word dropped")
  `MRS_ASSERT(a_resid_zero, out_valid_o && (status_o == ST_EVAL || status_o == ST_IDLE)
              |-> residual_o == '0, "residual on non-final word")
  `MRS_ASSERT(a_idle_point, out_valid_o && status_o == ST_IDLE |-> point_o == '0,
              "idle word with nonzero point")

endmodule

bind muller_root_step_real_unit mrs_chk u_mrs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .point_o     (point_o),
  .status_o    (status_o),
  .residual_o  (residual_o)
);

// ===== dv/muller_step_checker.sv =====
`timescale 1ns / 1ps
// Watches the config, input and output channels of the root finder, keeps its
// own model of the solver state and compares every output word in order.
module muller_step_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          mode_i,
  input  mrs_pkg::val_t                 function_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  mrs_pkg::val_t                 point_i,
  input  logic [2:0]                    status_i,
  input  logic [mrs_pkg::ITW-1:0]       iterations_i,
  input  logic [mrs_pkg::W-2:0]         residual_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [mrs_pkg::IDXW-1:0]      cfg_index_i,
  input  mrs_pkg::val_t                 cfg_data_i,
  output int                            failures_o,
  output int                            pending_o,
  output mrs_pkg::val_t                 last_point_o,
  output mrs_pkg::stat_e                last_status_o
);
  import mrs_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    val_t                 point;
    stat_e                status;
    logic [ITW-1:0]       iters;
    logic [W-2:0]         resid;
  } step_word_t;

  localparam wide_t WMAX = wide_t'(VMAX);
  localparam wide_t WMIN = -WMAX - 1;

  step_word_t     expected_words[$];
  val_t           start_pt[3];
  logic [W-2:0]   tol;
  logic [ITW-1:0] iter_limit;
  val_t           pts[3];
  val_t           vals[3];
  phase_e         solve_phase;
  logic [ITW-1:0] steps;

  function automatic wide_t wx(val_t v);
    return wide_t'(v);
  endfunction

  function automatic logic [W-1:0] abs_of(val_t v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Range check with saturation of the returned value.
  function automatic bit fit(wide_t a, output val_t o);
    if (a > WMAX) begin
      o = VMAX;
      return 1'b0;
    end
    if (a < WMIN) begin
      o = val_t'(WMIN);
      return 1'b0;
    end
    o = a[W-1:0];
    return 1'b1;
  endfunction

  function automatic bit qmul(val_t a, val_t b, output val_t o);
    wide_t p;
    p = wx(a) * wx(b);
    return fit(p >>> F, o);
  endfunction

  // Truncating quotient, den nonzero.
  function automatic bit qdiv(wide_t num, val_t den, output val_t o);
    wide_t q;
    q = (num <<< F) / wx(den);
    return fit(q, o);
  endfunction

  function automatic bit qsqrt(val_t v, output val_t o);
    logic [127:0] n;
    logic [63:0]  r;
    logic [63:0]  t;
    n = wx(v) <<< F;
    r = '0;
    for (int i = 62; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return fit(wide_t'(r), o);
  endfunction

  // One parabola fit through the held points; first failing check decides.
  function automatic stat_e parabola_step(output val_t xn);
    val_t x0, x1, x2, f0, f1, f2, h0, h1, hs, d0, d1, a, ah, b, bb, ac, ac4;
    val_t disc, s, e1, e2, den, dx;
    xn = '0;
    x0 = pts[0]; x1 = pts[1]; x2 = pts[2];
    f0 = vals[0]; f1 = vals[1]; f2 = vals[2];
    if (!fit(wx(x1) - wx(x0), h0) || !fit(wx(x2) - wx(x1), h1)) return ST_OVF;
    if (h0 == 0 || h1 == 0) return ST_ZERO;
    if (!qdiv(wx(f1) - wx(f0), h0, d0)) return ST_OVF;
    if (!qdiv(wx(f2) - wx(f1), h1, d1)) return ST_OVF;
    if (!fit(wx(h1) + wx(h0), hs)) return ST_OVF;
    if (hs == 0) return ST_ZERO;
    if (!qdiv(wx(d1) - wx(d0), hs, a)) return ST_OVF;
    if (!qmul(a, h1, ah) || !fit(wx(ah) + wx(d1), b)) return ST_OVF;
    if (!qmul(b, b, bb) || !qmul(a, f2, ac)) return ST_OVF;
    if (!fit(wx(ac) <<< 2, ac4) || !fit(wx(bb) - wx(ac4), disc)) return ST_OVF;
    if (disc < 0) return ST_COMPLEX;
    if (!qsqrt(disc, s)) return ST_OVF;
    if (!fit(wx(b) + wx(s), e1) || !fit(wx(b) - wx(s), e2)) return ST_OVF;
    den = (abs_of(e1) > abs_of(e2)) ? e1 : e2;
    if (den == 0) return ST_ZERO;
    if (!qdiv(-(wx(f2) <<< 1), den, dx)) return ST_OVF;
    if (!fit(wx(x2) + wx(dx), xn)) return ST_OVF;
    return ST_EVAL;
  endfunction

  function automatic void push_word(val_t p, stat_e st, logic [W-2:0] res);
    step_word_t w;
    w.point  = p;
    w.status = st;
    w.iters  = steps;
    w.resid  = res;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_step(logic mode, val_t f);
    logic [W-1:0] m;
    logic [W-2:0] res;
    stat_e        st;
    val_t         xn;
    if (mode == 1'b0) begin
      pts = start_pt;
      steps = '0;
      solve_phase = PH_WAIT0;
      push_word(pts[0], ST_EVAL, '0);
      return;
    end
    case (solve_phase)
      PH_WAIT0: begin
        vals[0] = f;
        solve_phase = PH_WAIT1;
        push_word(pts[1], ST_EVAL, '0);
        return;
      end
      PH_WAIT1: begin
        vals[1] = f;
        solve_phase = PH_WAIT2;
        push_word(pts[2], ST_EVAL, '0);
        return;
      end
      PH_WAIT2: ;
      default: begin
        push_word('0, ST_IDLE, '0);
        return;
      end
    endcase
    vals[2] = f;
    m = abs_of(f);
    res = m[W-1] ? {(W-1){1'b1}} : m[W-2:0];
    if (steps >= iter_limit) begin
      solve_phase = PH_IDLE;
      push_word(pts[2], ST_LIMIT, res);
      return;
    end
    if (m < {1'b0, tol}) begin
      solve_phase = PH_IDLE;
      push_word(pts[2], ST_CONV, res);
      return;
    end
    st = parabola_step(xn);
    if (st != ST_EVAL) begin
      solve_phase = PH_IDLE;
      push_word(pts[2], st, res);
      return;
    end
    pts[0] = pts[1]; vals[0] = vals[1];
    pts[1] = pts[2]; vals[1] = vals[2];
    pts[2] = xn;
    steps = steps + 1'b1;
    push_word(xn, ST_EVAL, '0);
  endfunction

  assign pending_o = expected_words.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    step_word_t w;
    if (!rst_ni) begin
      start_pt[0] = '0;
      start_pt[1] = val_t'(1) <<< (F - 1);
      start_pt[2] = -(val_t'(1) <<< (F - 1));
      tol = 4295;
      iter_limit = 100;
      solve_phase = PH_IDLE;
      steps = '0;
      expected_words.delete();
      failures_o <= 0;
      last_point_o <= '0;
      last_status_o <= ST_IDLE;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FIRST:  start_pt[0] = cfg_data_i;
          CFG_SECOND: start_pt[1] = cfg_data_i;
          CFG_THIRD:  start_pt[2] = cfg_data_i;
          CFG_TOL:    tol = cfg_data_i[W-2:0];
          CFG_LIMIT:  iter_limit = cfg_data_i[ITW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        last_point_o <= point_i;
        last_status_o <= stat_e'(status_i);
        if (expected_words.size() == 0) begin
          $error("unexpected word: point %0d status %0d", point_i, status_i);
          failures_o <= failures_o + 1;
        end else begin
          w = expected_words.pop_front();
          if (point_i !== w.point || status_i !== w.status ||
              iterations_i !== w.iters || residual_i !== w.resid) begin
            failures_o <= failures_o + 1;
            if (point_i !== w.point)
              $error("point: expected %0d actual %0d", w.point, point_i);
            if (status_i !== w.status)
              $error("status: expected %0d actual %0d", w.status, status_i);
            if (iterations_i !== w.iters)
              $error("iterations: expected %0d actual %0d", w.iters, iterations_i);
            if (residual_i !== w.resid)
              $error("residual: expected %0d actual %0d", w.resid, residual_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_step(mode_i, function_value_i);
    end
  end

endmodule

// ===== dv/tb_muller_root_step_real_unit.sv =====
`timescale 1ns / 1ps
// Top of the root finder bench: drives config, input words and output stalls,
// lets the checker predict and compare, and gives the verdict.
module tb_muller_root_step_real_unit;
  import mrs_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int  ITEM_TARGET = 1250;
  localparam int  CYCLE_LIMIT = 20_000_000;
  localparam int  DRAIN       = 700;
  localparam wide_t WMAX      = wide_t'(VMAX);
  localparam val_t  ONE       = val_t'(1) <<< F;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                mode = 1'b0;
  val_t                fval = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  val_t                point;
  logic [2:0]          status;
  logic [ITW-1:0]      iterations;
  logic [W-2:0]        residual;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDXW-1:0]     cfg_index = '0;
  val_t                cfg_data = '0;

  int                  failures;
  int                  pending;
  val_t                last_point;
  stat_e               last_status;

  int                  items_sent = 0;
  int                  cycles = 0;
  int                  snd_idle = 0;  // percent of cycles the sender idles
  int                  rcv_stall = 0; // percent of cycles the receiver stalls

  // Test function: (x - r0)(x - r1) + c, saturated to the value range.
  val_t                root_a, root_b, offset_c;

  always #5 clk_i = ~clk_i;

  muller_root_step_real_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .function_value_i(fval),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .point_o(point), .status_o(status), .iterations_o(iterations),
    .residual_o(residual),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  muller_step_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .mode_i(mode), .function_value_i(fval),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .point_i(point), .status_i(status), .iterations_i(iterations),
    .residual_i(residual),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .failures_o(failures), .pending_o(pending),
    .last_point_o(last_point), .last_status_o(last_status)
  );

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= rcv_stall);

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic val_t rand_word();
    return val_t'({$urandom, $urandom});
  endfunction

  // Small value in about [-span, span] units.
  function automatic val_t rand_near(int span);
    wide_t v;
    v = $signed({1'b0, $urandom_range(2 * span * 256)}) - span * 256;
    return val_t'((v <<< (F - 8)) + $urandom_range(16777215));
  endfunction

  function automatic val_t func_at(val_t x);
    wide_t p;
    p = ((wide_t'(x) - wide_t'(root_a)) * (wide_t'(x) - wide_t'(root_b))) >>> F;
    p = p + wide_t'(offset_c);
    if (p > WMAX) return VMAX;
    if (p < -WMAX - 1) return val_t'(-WMAX - 1);
    return val_t'(p);
  endfunction

  task automatic sender_gap();
    int n;
    n = 0;
    while (n < 20 && $urandom_range(99) < snd_idle) n++;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // One input word; returns after the edge that accepted it.
  task automatic send_word(logic m, val_t f);
    sender_gap();
    in_valid <= 1'b1;
    mode <= m;
    fval <= f;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    in_valid <= 1'b0;
    items_sent++;
  endtask

  task automatic wait_results();
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, val_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Start, then answer every evaluate request with f at that point; a few
  // answers are noise, and long solves get abandoned by the next start.
  task automatic run_solve(int max_words);
    int n;
    root_a = rand_near(3);
    root_b = ($urandom_range(3) == 0) ? root_a : rand_near(6);
    offset_c = ($urandom_range(3) == 0) ? rand_near(2) : '0;
    send_word(1'b0, rand_word());
    for (n = 0; n < max_words; n++) begin
      wait_results();
      if (last_status != ST_EVAL) break;
      if ($urandom_range(99) < 8) send_word(1'b1, rand_word());
      else send_word(1'b1, func_at(last_point));
    end
  endtask

  task automatic set_config(int setting);
    case (setting)
      0: begin
        // extremes: huge spread, loosest tolerance, a limit of one step
        write_reg(CFG_FIRST, VMAX);
        write_reg(CFG_SECOND, val_t'(-WMAX - 1));
        write_reg(CFG_THIRD, '0);
        write_reg(CFG_TOL, VMAX);
        write_reg(CFG_LIMIT, val_t'(1));
      end
      1: begin
        // zero tolerance, longest limit
        write_reg(CFG_FIRST, rand_near(2));
        write_reg(CFG_SECOND, rand_near(2));
        write_reg(CFG_THIRD, rand_near(2));
        write_reg(CFG_TOL, '0);
        write_reg(CFG_LIMIT, val_t'(16'hFFFF));
      end
      2: begin
        // coincident starting points: zero divisor
        write_reg(CFG_FIRST, ONE);
        write_reg(CFG_SECOND, ONE);
        write_reg(CFG_THIRD, -ONE);
        write_reg(CFG_TOL, val_t'(4295));
        write_reg(CFG_LIMIT, val_t'(100));
      end
      default: begin
        write_reg(CFG_FIRST, rand_near(4));
        write_reg(CFG_SECOND, rand_near(4));
        write_reg(CFG_THIRD, rand_near(4));
        write_reg(CFG_TOL, val_t'($urandom_range(1 << 20)));
        write_reg(CFG_LIMIT, val_t'($urandom_range(40, 1)));
      end
    endcase
  endtask

  initial begin
    int setting;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: values while idle, extremes of the value field.
    send_word(1'b1, VMAX);
    send_word(1'b1, val_t'(-WMAX - 1));
    send_word(1'b1, '0);
    // Default start points, a well-behaved solve.
    root_a = ONE >>> 2; root_b = -ONE; offset_c = '0;
    send_word(1'b0, '0);
    repeat (8) begin
      wait_results();
      if (last_status != ST_EVAL) break;
      send_word(1'b1, func_at(last_point));
    end
    // Start while busy, then a solve with no real root.
    send_word(1'b0, VMAX);
    send_word(1'b1, VMAX);
    root_a = '0; root_b = '0; offset_c = ONE;
    send_word(1'b0, '0);
    repeat (4) begin
      wait_results();
      if (last_status != ST_EVAL) break;
      send_word(1'b1, func_at(last_point));
    end
    // Overflowing values into a fresh solve.
    send_word(1'b0, '0);
    send_word(1'b1, VMAX);
    send_word(1'b1, val_t'(-WMAX - 1));
    send_word(1'b1, VMAX);
    wait_results();

    // Random phases; config only once the engine has drained.
    setting = 0;
    while (items_sent < ITEM_TARGET) begin
      case (setting % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 60; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 60; end
        default: begin snd_idle = 22; rcv_stall = 22; end
      endcase
      wait_results();
      repeat (DRAIN) @(posedge clk_i);
      set_config(setting % 6);
      repeat (12) run_solve(($urandom_range(9) == 0) ? 60 : 14);
      setting++;
    end

    in_valid <= 1'b0;
    wait_results();
    repeat (DRAIN) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
